// ===== design/mt64_pkg.sv =====
// shared types and constants for the 64-bit mersenne twister generator
// no dependencies
package mt64_pkg;

    localparam int STATE_WORDS  = 312;
    localparam int SHIFT_OFFSET = 156;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int WORD_W       = 64;

    localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UPPER_BITS   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LOWER_BITS   = 64'h000000007FFFFFFF;
    localparam logic [63:0] TEMPER_D     = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_B     = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_C     = 64'hFFF7EEE000000000;
    localparam logic [63:0] INIT_MULT    = 64'd6364136223846793005;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        K_SEED = 2'd0,
        K_DRAW = 2'd1,
        K_NULL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] seed;
    } t_cmd;

endpackage

// ===== design/mt64_if.sv =====
// item channels of the generator: command in, result out
// depends on nothing
interface mt64_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] seed_value;
    modport source(output valid, output opcode, output seed_value, input ready);
    modport sink(input valid, input opcode, input seed_value, output ready);
endinterface

interface mt64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] number;
    logic        ok;
    modport source(output valid, output number, output ok, input ready);
    modport sink(input valid, input number, input ok, output ready);
endinterface

// ===== design/mersenne_twister_64_generator_core.sv =====
// top level of the 64-bit mersenne twister generator
// depends on mt64_pkg, mt64_if, mt64_front and mt64_back
//
// usage:
//   i_cmd carries one command per item: opcode 0 seeds with seed_value,
//   opcode 1 draws one number. o_result returns exactly one item per
//   command, in order: number and ok (ok low and number zero for seeds
//   and for draws before the first seed).
//   a two-entry queue sits between the command front end and the back
//   end, so commands are taken while the back end works or the output
//   waits.
//   a draw that finds the table used up (the first after a seed, then every
//   312th) first rewrites the state table in place, word by word through
//   S_TW_RD and S_TW_WR, via the two-read-port state ram. a seed writes each
//   word through S_SEED_MUL and S_SEED_ADD, as the 64-bit multiply is split.
//   reset empties the queue, clears the seeded flag and the output valid
//   flag; the state table itself is not cleared.
//   when the receiver holds ready low the result register keeps its
//   item and the queue fills, then i_cmd.ready drops.
module mersenne_twister_64_generator_core
    import mt64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mt64_in_if.sink    i_cmd,
    mt64_out_if.source o_result
);
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    mt64_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_pop   (w_q_pop)
    );

    mt64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_result  (o_result)
    );
endmodule

// ===== design/mt64_ram.sv =====
// generic ram, one write port, two registered read ports
// depends on nothing
module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule

// ===== design/mt64_front.sv =====
// front end: accepts commands, classifies them, queues them for the back end
// depends on mt64_pkg and mt64_in_if
module mt64_front
    import mt64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mt64_in_if.sink    i_cmd,
    output logic       o_q_valid,
    output t_cmd       o_q_cmd,
    input  logic       i_q_pop
);
    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       r_seeded;
    logic       w_push;
    t_cmd       w_cmd;

    assign i_cmd.ready = (r_count != 2'd2);
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_count != 2'd0);
    assign o_q_cmd     = r_q[r_rd_ptr];

    always_comb begin
        w_cmd.seed = i_cmd.seed_value;
        if (i_cmd.opcode == OP_SEED) begin
            w_cmd.kind = K_SEED;
        end else if (r_seeded) begin
            w_cmd.kind = K_DRAW;
        end else begin
            w_cmd.kind = K_NULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_seeded <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
                if (i_cmd.opcode == OP_SEED) begin
                    r_seeded <= 1'b1;
                end
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

// ===== design/mt64_back.sv =====
// back end: seeding, table twist and tempering over the state ram
// depends on mt64_pkg, mt64_out_if and mt64_ram
module mt64_back
    import mt64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    mt64_out_if.source o_result
);
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SEED_MUL = 8'b0000_0010,
        S_SEED_ADD = 8'b0000_0100,
        S_TW_LD    = 8'b0000_1000,
        S_TW_RD    = 8'b0001_0000,
        S_TW_WR    = 8'b0010_0000,
        S_DRAW_RD  = 8'b0100_0000,
        S_DRAW_OUT = 8'b1000_0000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] END_ADDR  = ADDR_W'(STATE_WORDS);

    function automatic logic [63:0] f_mix(logic [63:0] hi_w, logic [63:0] lo_w,
                                          logic [63:0] far_w);
        logic [63:0] y;
        logic [63:0] r;
        y = (hi_w & UPPER_BITS) | (lo_w & LOWER_BITS);
        r = far_w ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic logic [63:0] f_temper(logic [63:0] x_in);
        logic [63:0] x;
        x = x_in;
        x = x ^ ((x >> 29) & TEMPER_D);
        x = x ^ ((x << 17) & TEMPER_B);
        x = x ^ ((x << 37) & TEMPER_C);
        x = x ^ (x >> 43);
        return x;
    endfunction

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [63:0]       r_cur, n_cur;
    logic [63:0]       r_x, n_x;
    logic [63:0]       r_pll, n_pll;
    logic [31:0]       r_pc, n_pc;
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_number, n_number;
    logic              r_ok, n_ok;

    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_ra, w_rb;
    logic [63:0]       w_wdata, w_rd_a, w_rd_b;
    logic              w_out_free;
    logic [63:0]       w_v, w_pll, w_sum;
    logic [31:0]       w_pc;
    logic [ADDR_W-1:0] w_nxt, w_far;
    logic [ADDR_W:0]   w_far_raw;

    mt64_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_v        = r_x ^ (r_x >> 62);
    assign w_pll      = 64'(w_v[31:0]) * 64'(INIT_MULT[31:0]);
    assign w_pc       = w_v[31:0] * INIT_MULT[63:32] + w_v[63:32] * INIT_MULT[31:0];
    assign w_sum      = r_pll + {r_pc, 32'd0} + 64'(r_k);
    assign w_nxt      = (r_k == LAST_ADDR) ? '0 : r_k + 1'b1;
    assign w_far_raw  = {1'b0, r_k} + (ADDR_W + 1)'(SHIFT_OFFSET);
    assign w_far      = (w_far_raw >= (ADDR_W + 1)'(STATE_WORDS))
                      ? ADDR_W'(w_far_raw - (ADDR_W + 1)'(STATE_WORDS))
                      : ADDR_W'(w_far_raw);

    assign o_result.valid  = r_out_valid;
    assign o_result.number = r_number;
    assign o_result.ok     = r_ok;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_x         = r_x;
        n_pll       = r_pll;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !o_result.ready;
        n_number    = r_number;
        n_ok        = r_ok;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_k;
        w_wdata     = w_sum;
        w_re        = 1'b0;
        w_ra        = w_nxt;
        w_rb        = w_far;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.kind)
                        K_SEED: begin
                            w_we        = 1'b1;
                            w_waddr     = '0;
                            w_wdata     = i_q_cmd.seed;
                            n_x         = i_q_cmd.seed;
                            n_k         = ADDR_W'(1);
                            n_out_valid = 1'b1;
                            n_number    = '0;
                            n_ok        = 1'b0;
                            n_state     = S_SEED_MUL;
                        end
                        K_DRAW: begin
                            w_re = 1'b1;
                            n_k  = '0;
                            if (r_idx == END_ADDR) begin
                                w_ra    = '0;
                                n_state = S_TW_LD;
                            end else begin
                                w_ra    = r_idx;
                                n_state = S_DRAW_OUT;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_number    = '0;
                            n_ok        = 1'b0;
                        end
                    endcase
                end
            end
            S_SEED_MUL: begin
                n_pll   = w_pll;
                n_pc    = w_pc;
                n_state = S_SEED_ADD;
            end
            S_SEED_ADD: begin
                w_we = 1'b1;
                n_x  = w_sum;
                if (r_k == LAST_ADDR) begin
                    n_idx   = END_ADDR;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SEED_MUL;
                end
            end
            S_TW_LD: begin
                n_cur   = w_rd_a;
                w_re    = 1'b1;
                n_state = S_TW_WR;
            end
            S_TW_RD: begin
                w_re    = 1'b1;
                n_state = S_TW_WR;
            end
            S_TW_WR: begin
                w_we    = 1'b1;
                w_wdata = f_mix(r_cur, w_rd_a, w_rd_b);
                n_cur   = w_rd_a;
                if (r_k == LAST_ADDR) begin
                    n_idx   = '0;
                    n_state = S_DRAW_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_TW_RD;
                end
            end
            S_DRAW_RD: begin
                w_re    = 1'b1;
                w_ra    = r_idx;
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_number    = f_temper(w_rd_a);
                    n_ok        = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_x      <= n_x;
        r_pll    <= n_pll;
        r_pc     <= n_pc;
        r_number <= n_number;
        r_ok     <= n_ok;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= END_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== design/mt64_checker.sv =====
// port-level checks for the generator top level
// depends on mersenne_twister_64_generator_core, attached by bind
module mt64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_number,
    input logic        i_ok
);
    // results without ok carry zero
    a_zero_when_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_number == 64'd0)
        else $error("non-ok result with nonzero number");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_number) && $stable(i_ok))
        else $error("stalled result changed");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // no result without a command accepted earlier
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n ##1 (i_rst_n && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result with no command");
endmodule

bind mersenne_twister_64_generator_core mt64_checker u_mt64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_number    (o_result.number),
    .i_ok        (o_result.ok)
);

// ===== tb/tb_mersenne_twister_64_generator_core.sv =====
// testbench for the 64-bit mersenne twister generator core
// predicts every result with its own twister model and checks items in order
// depends on mt64_pkg, mt64_if and the core
module tb_mersenne_twister_64_generator_core;
    import mt64_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] number;
        logic        ok;
    } t_draw_result;

    logic i_clk;
    logic i_rst_n;

    mt64_in_if  cmd_if();
    mt64_out_if res_if();

    mersenne_twister_64_generator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_result(res_if.source)
    );

    logic [63:0]  mt_words [STATE_WORDS];
    int           mt_index;
    bit           mt_seeded;
    t_draw_result pending_results[$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] temper_word(logic [63:0] x);
        x ^= (x >> 29) & TEMPER_D;
        x ^= (x << 17) & TEMPER_B;
        x ^= (x << 37) & TEMPER_C;
        x ^= x >> 43;
        return x;
    endfunction

    function automatic void twist_table();
        logic [63:0] y;
        logic [63:0] r;
        for (int k = 0; k < STATE_WORDS; k++) begin
            y = (mt_words[k] & UPPER_BITS) | (mt_words[(k + 1) % STATE_WORDS] & LOWER_BITS);
            r = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0]) r ^= TWIST_MATRIX;
            mt_words[k] = r;
        end
    endfunction

    function automatic t_draw_result predict_result(logic op, logic [63:0] seed);
        t_draw_result res;
        logic [63:0] p;
        res.number = '0;
        res.ok     = 1'b0;
        if (op == OP_SEED) begin
            mt_words[0] = seed;
            for (int k = 1; k < STATE_WORDS; k++) begin
                p = mt_words[k - 1];
                mt_words[k] = INIT_MULT * (p ^ (p >> 62)) + 64'(k);
            end
            mt_index  = STATE_WORDS;
            mt_seeded = 1'b1;
        end else if (mt_seeded) begin
            if (mt_index >= STATE_WORDS) begin
                twist_table();
                mt_index = 0;
            end
            res.number = temper_word(mt_words[mt_index]);
            res.ok     = 1'b1;
            mt_index++;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(logic op, logic [63:0] seed);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= op;
        cmd_if.seed_value <= seed;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_result(op, seed));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // receiver ready and long hold-offs
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            res_if.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            res_if.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (res_if.number !== want.number)
                    report_mismatch($sformatf("number %h, expected %h",
                                              res_if.number, want.number));
                if (res_if.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, expected %b", res_if.ok, want.ok));
            end
        end
    end

    task automatic test_unseeded_draws();
        send_item(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, {$urandom(), $urandom()});
    endtask

    task automatic test_seed_extremes();
        send_item(OP_SEED, '0);
        repeat (3) send_item(OP_DRAW, '0);
        send_item(OP_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        repeat (3) send_item(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_SEED, 64'd5489);
        repeat (4) send_item(OP_DRAW, '0);
        send_item(OP_SEED, 64'h8000_0000_0000_0001);
        send_item(OP_SEED, 64'h5555_AAAA_5555_AAAA);
        send_item(OP_DRAW, '0);
    endtask

    task automatic test_table_wrap();
        // crosses the twist boundary twice in one seed run
        send_item(OP_SEED, {$urandom(), $urandom()});
        repeat (2 * STATE_WORDS + 5) send_item(OP_DRAW, {$urandom(), $urandom()});
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        repeat (12) send_item(OP_DRAW, '0);
        wait_drained();
        send_item(OP_SEED, {$urandom(), $urandom()});
        wait_drained();
        send_item(OP_DRAW, '0);
    endtask

    task automatic test_random_mix(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99, 0) < 3)
                send_item(OP_SEED, {$urandom(), $urandom()});
            else
                send_item(OP_DRAW, {$urandom(), $urandom()});
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        mt_index        = STATE_WORDS;
        mt_seeded       = 1'b0;
        foreach (mt_words[k]) mt_words[k] = '0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_DRAW;
        cmd_if.seed_value = '0;
        res_if.ready      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unseeded_draws();
        test_seed_extremes();
        send_idle_pct = 8;
        recv_idle_pct = 65;
        test_table_wrap();
        test_random_mix(200);
        send_idle_pct = 65;
        recv_idle_pct = 8;
        test_backpressure();
        test_random_mix(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(250);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== mersenne_twister_64_generator_core.f =====
design/mt64_pkg.sv
design/mt64_if.sv
design/mt64_ram.sv
design/mt64_front.sv
design/mt64_back.sv
design/mersenne_twister_64_generator_core.sv
design/mt64_checker.sv
tb/tb_mersenne_twister_64_generator_core.sv
